FILE: rtl/core/qmap_pkg.sv
// qmap_pkg: shared constants, opcodes and the step micro-program of the quadratic map core
// no dependencies; compiled first
package qmap_pkg;

  localparam int unsigned WORD_BITS_DEF = 64;
  localparam int unsigned FRAC_W        = 6;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 6'd60;
  localparam int unsigned COEF_COUNT    = 12;
  localparam int unsigned COEF_IDX_W    = 4;
  localparam int unsigned PC_W          = 4;
  localparam logic [PC_W-1:0] UOP_LAST  = 4'd10;

  // item opcodes
  typedef enum logic [1:0] {
    OP_WRITE_COEF = 2'd0,
    OP_LOAD       = 2'd1,
    OP_STEP       = 2'd2
  } opcode_e;

  // coefficient offsets within one coordinate's group of six
  localparam logic [COEF_IDX_W-1:0] CF_CONST  = 4'd0;
  localparam logic [COEF_IDX_W-1:0] CF_X_LIN  = 4'd1;
  localparam logic [COEF_IDX_W-1:0] CF_X_SQR  = 4'd2;
  localparam logic [COEF_IDX_W-1:0] CF_XY     = 4'd3;
  localparam logic [COEF_IDX_W-1:0] CF_Y_LIN  = 4'd4;
  localparam logic [COEF_IDX_W-1:0] CF_Y_SQR  = 4'd5;
  localparam logic [COEF_IDX_W-1:0] CF_Y_BASE = 4'd6;

  // multiplier operand sources
  typedef enum logic [1:0] {
    OPA_X    = 2'd0,
    OPA_XY   = 2'd1,
    OPA_T    = 2'd2,
    OPA_COEF = 2'd3
  } opa_e;

  typedef enum logic [1:0] {
    OPB_X    = 2'd0,
    OPB_Y    = 2'd1,
    OPB_COEF = 2'd2
  } opb_e;

  // what happens to a finished product
  typedef enum logic [2:0] {
    POST_XY       = 3'd0,
    POST_T        = 3'd1,
    POST_ACC_INIT = 3'd2,
    POST_ACC_ADD  = 3'd3,
    POST_NX       = 3'd4,
    POST_NY       = 3'd5
  } post_e;

  typedef struct packed {
    opa_e                  opa;
    opb_e                  opb;
    post_e                 post;
    logic [COEF_IDX_W-1:0] coef_mul;
    logic [COEF_IDX_W-1:0] coef_add;
  } uop_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ctrl_stat_t;

  // micro-program of one map step: x*y once, then five products per coordinate
  function automatic uop_t get_uop(input logic [PC_W-1:0] pc);
    uop_t                  u;
    logic [COEF_IDX_W-1:0] base;
    logic [PC_W-1:0]       k;
    base       = (pc > 4'd5) ? CF_Y_BASE : '0;
    k          = (pc > 4'd5) ? (pc - 4'd5) : pc;
    u.opa      = OPA_X;
    u.opb      = OPB_Y;
    u.post     = POST_XY;
    u.coef_mul = '0;
    u.coef_add = '0;
    case (k)
      4'd1: begin
        u.opa      = OPA_COEF;
        u.opb      = OPB_X;
        u.post     = POST_T;
        u.coef_mul = base + CF_X_SQR;
        u.coef_add = base + CF_X_LIN;
      end
      4'd2: begin
        u.opa      = OPA_T;
        u.opb      = OPB_X;
        u.post     = POST_ACC_INIT;
        u.coef_add = base + CF_CONST;
      end
      4'd3: begin
        u.opa      = OPA_XY;
        u.opb      = OPB_COEF;
        u.post     = POST_ACC_ADD;
        u.coef_mul = base + CF_XY;
      end
      4'd4: begin
        u.opa      = OPA_COEF;
        u.opb      = OPB_Y;
        u.post     = POST_T;
        u.coef_mul = base + CF_Y_SQR;
        u.coef_add = base + CF_Y_LIN;
      end
      4'd5: begin
        u.opa  = OPA_T;
        u.opb  = OPB_Y;
        u.post = (base == CF_Y_BASE) ? POST_NY : POST_NX;
      end
      default: begin
        u.opa  = OPA_X;
        u.opb  = OPB_Y;
        u.post = POST_XY;
      end
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/core/qmap_in_if.sv
// qmap_in_if: input channel of the quadratic map core, valid/ready with one item per beat
// no dependencies
interface qmap_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [3:0]         coef_index;
  logic signed [63:0] coef_value;
  logic signed [63:0] x_start;
  logic signed [63:0] y_start;

  modport source (
    output valid, opcode, coef_index, coef_value, x_start, y_start,
    input  ready
  );
  modport sink (
    input  valid, opcode, coef_index, coef_value, x_start, y_start,
    output ready
  );
endinterface

FILE: rtl/core/qmap_out_if.sv
// qmap_out_if: result channel of the quadratic map core, valid/ready with one point per beat
// no dependencies
interface qmap_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] x_out;
  logic signed [63:0] y_out;

  modport source (
    output valid, x_out, y_out,
    input  ready
  );
  modport sink (
    input  valid, x_out, y_out,
    output ready
  );
endinterface

FILE: rtl/core/qmap_mul.sv
// qmap_mul: shared multi-cycle fixed-point multiplier, four half-word partial products
// then an arithmetic right shift by the fraction bits; uses qmap_pkg
module qmap_mul #(
  parameter int unsigned WORD_BITS = qmap_pkg::WORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [WORD_BITS-1:0]         a_i,
  input  logic [WORD_BITS-1:0]         b_i,
  input  logic [qmap_pkg::FRAC_W-1:0]  frac_bits_i,
  output logic                         done_o,
  output logic [WORD_BITS-1:0]         result_o
);
  import qmap_pkg::*;

  localparam int unsigned HalfBits = (WORD_BITS + 1) / 2;
  localparam int unsigned PpBits   = 2 * HalfBits + 2;
  localparam int unsigned ProdBits = 2 * WORD_BITS;

  typedef enum logic [1:0] {
    MU_IDLE,
    MU_RUN,
    MU_DRAIN,
    MU_SHIFT
  } mu_state_e;

  mu_state_e                  state_q, state_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic [WORD_BITS-1:0]       a_q, a_d, b_q, b_d;
  logic signed [PpBits-1:0]   pp_q, pp_d;
  logic [1:0]                 pp_sh_q, pp_sh_d;
  logic [ProdBits-1:0]        prod_q, prod_d;
  logic [WORD_BITS-1:0]       res_q, res_d;
  logic                       done_q, done_d;

  logic signed [HalfBits:0]   a_lo, a_hi, b_lo, b_hi, op_a, op_b;
  logic signed [PpBits-1:0]   pp_new;
  logic [ProdBits-1:0]        pp_ext, pp_aligned, prod_sum;
  logic signed [ProdBits-1:0] prod_shr;

  // low halves unsigned, high halves signed
  assign a_lo = $signed({1'b0, a_q[HalfBits-1:0]});
  assign b_lo = $signed({1'b0, b_q[HalfBits-1:0]});
  assign a_hi = (HalfBits+1)'($signed(a_q[WORD_BITS-1:HalfBits]));
  assign b_hi = (HalfBits+1)'($signed(b_q[WORD_BITS-1:HalfBits]));

  assign op_a   = cnt_q[1] ? a_hi : a_lo;
  assign op_b   = cnt_q[0] ? b_hi : b_lo;
  assign pp_new = op_a * op_b;

  assign pp_ext = ProdBits'(pp_q);
  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_aligned = pp_ext;
      2'd1:    pp_aligned = pp_ext << HalfBits;
      2'd2:    pp_aligned = pp_ext << (2 * HalfBits);
      default: pp_aligned = '0;
    endcase
  end

  assign prod_sum = prod_q + pp_aligned;
  assign prod_shr = $signed(prod_q) >>> frac_bits_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    pp_d    = pp_q;
    pp_sh_d = pp_sh_q;
    prod_d  = prod_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      MU_IDLE: begin
        if (start_i) begin
          a_d     = a_i;
          b_d     = b_i;
          cnt_d   = '0;
          pp_d    = '0;
          pp_sh_d = '0;
          prod_d  = '0;
          state_d = MU_RUN;
        end
      end
      MU_RUN: begin
        prod_d  = prod_sum;
        pp_d    = pp_new;
        pp_sh_d = 2'(cnt_q[1]) + 2'(cnt_q[0]);
        cnt_d   = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = MU_DRAIN;
        end
      end
      MU_DRAIN: begin
        prod_d  = prod_sum;
        state_d = MU_SHIFT;
      end
      MU_SHIFT: begin
        res_d   = prod_shr[WORD_BITS-1:0];
        done_d  = 1'b1;
        state_d = MU_IDLE;
      end
      default: begin
        state_d = MU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MU_IDLE;
      cnt_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      pp_q    <= '0;
      pp_sh_q <= '0;
      prod_q  <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      a_q     <= a_d;
      b_q     <= b_d;
      pp_q    <= pp_d;
      pp_sh_q <= pp_sh_d;
      prod_q  <= prod_d;
      res_q   <= res_d;
      done_q  <= done_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: rtl/core/qmap_ctrl.sv
// qmap_ctrl: coefficient store, point registers and the step sequencer driving qmap_mul
// uses qmap_pkg and qmap_mul
module qmap_ctrl #(
  parameter int unsigned WORD_BITS = qmap_pkg::WORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [qmap_pkg::FRAC_W-1:0]     frac_bits_i,
  input  logic                            item_i,
  input  logic [1:0]                      opcode_i,
  input  logic [qmap_pkg::COEF_IDX_W-1:0] coef_index_i,
  input  logic [WORD_BITS-1:0]            coef_value_i,
  input  logic [WORD_BITS-1:0]            x_start_i,
  input  logic [WORD_BITS-1:0]            y_start_i,
  input  logic                            res_take_i,
  output qmap_pkg::ctrl_stat_t            stat_o,
  output logic [WORD_BITS-1:0]            x_o,
  output logic [WORD_BITS-1:0]            y_o
);
  import qmap_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_RESULT
  } ctrl_state_e;

  ctrl_state_e          state_q, state_d;
  logic [PC_W-1:0]      pc_q, pc_d;
  logic [WORD_BITS-1:0] coef_q [COEF_COUNT];
  logic [WORD_BITS-1:0] coef_d [COEF_COUNT];
  logic [WORD_BITS-1:0] x_q, x_d, y_q, y_d, nx_q, nx_d;
  logic [WORD_BITS-1:0] xy_q, xy_d, t_q, t_d, acc_q, acc_d;

  uop_t                  uop;
  logic [COEF_IDX_W-1:0] coef_addr;
  logic [WORD_BITS-1:0]  coef_rd;
  logic                  mul_start, mul_done;
  logic [WORD_BITS-1:0]  mul_a, mul_b, mul_res;
  logic [WORD_BITS-1:0]  sum_coef, sum_acc;

  assign uop = get_uop(pc_q);

  // one coefficient read a cycle: product operand at issue, addend at completion
  assign coef_addr = (state_q == S_WAIT) ? uop.coef_add : uop.coef_mul;
  assign coef_rd   = coef_q[coef_addr];

  always_comb begin
    case (uop.opa)
      OPA_X:    mul_a = x_q;
      OPA_XY:   mul_a = xy_q;
      OPA_T:    mul_a = t_q;
      OPA_COEF: mul_a = coef_rd;
      default:  mul_a = '0;
    endcase
    case (uop.opb)
      OPB_X:    mul_b = x_q;
      OPB_Y:    mul_b = y_q;
      OPB_COEF: mul_b = coef_rd;
      default:  mul_b = '0;
    endcase
  end

  assign mul_start = (state_q == S_ISSUE);
  assign sum_coef  = mul_res + coef_rd;
  assign sum_acc   = acc_q + mul_res;

  qmap_mul #(
    .WORD_BITS (WORD_BITS)
  ) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mul_start),
    .a_i         (mul_a),
    .b_i         (mul_b),
    .frac_bits_i (frac_bits_i),
    .done_o      (mul_done),
    .result_o    (mul_res)
  );

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    coef_d  = coef_q;
    x_d     = x_q;
    y_d     = y_q;
    nx_d    = nx_q;
    xy_d    = xy_q;
    t_d     = t_q;
    acc_d   = acc_q;
    case (state_q)
      S_IDLE: begin
        if (item_i) begin
          case (opcode_i)
            OP_WRITE_COEF: begin
              if (coef_index_i < COEF_IDX_W'(COEF_COUNT)) begin
                coef_d[coef_index_i] = coef_value_i;
              end
            end
            OP_LOAD: begin
              x_d     = x_start_i;
              y_d     = y_start_i;
              state_d = S_RESULT;
            end
            OP_STEP: begin
              pc_d    = '0;
              state_d = S_ISSUE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ISSUE: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mul_done) begin
          case (uop.post)
            POST_XY:       xy_d  = mul_res;
            POST_T:        t_d   = sum_coef;
            POST_ACC_INIT: acc_d = sum_coef;
            POST_ACC_ADD:  acc_d = sum_acc;
            POST_NX:       nx_d  = sum_acc;
            POST_NY: begin
              x_d = nx_q;
              y_d = sum_acc;
            end
            default: acc_d = acc_q;
          endcase
          if (pc_q == UOP_LAST) begin
            state_d = S_RESULT;
          end else begin
            pc_d    = pc_q + 4'd1;
            state_d = S_ISSUE;
          end
        end
      end
      S_RESULT: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      for (int i = 0; i < COEF_COUNT; i++) begin
        coef_q[i] <= '0;
      end
      x_q   <= '0;
      y_q   <= '0;
      nx_q  <= '0;
      xy_q  <= '0;
      t_q   <= '0;
      acc_q <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      coef_q  <= coef_d;
      x_q     <= x_d;
      y_q     <= y_d;
      nx_q    <= nx_d;
      xy_q    <= xy_d;
      t_q     <= t_d;
      acc_q   <= acc_d;
    end
  end

  assign stat_o.idle      = (state_q == S_IDLE);
  assign stat_o.res_valid = (state_q == S_RESULT);
  assign x_o              = x_q;
  assign y_o              = y_q;

endmodule

FILE: rtl/core/quadratic_2d_map_fixed_point.sv
// quadratic_2d_map_fixed_point: top level of the two-dimensional quadratic map core
// uses qmap_pkg, qmap_in_if, qmap_out_if and qmap_ctrl (which holds qmap_mul)
//
// Iterates x' = c0 + (c2*x + c1)*x + (x*y)*c3 + (c5*y + c4)*y and the matching y' with
// c6..c11, in WORD_BITS-bit two's-complement fixed point. Every product is the full signed
// double-width product shifted arithmetically right by frac_bits, low WORD_BITS kept; all
// sums wrap. Input beats: opcode 0 writes coefficient coef_index (indexes 12..15 are
// dropped), opcode 1 loads (x_start, y_start) and returns it, opcode 2 runs one map step
// and returns the new point, opcode 3 is ignored. Inputs keep their low WORD_BITS bits,
// results are sign-extended to 64 bits. Coefficients, point and frac_bits (60) are set by
// reset. A coefficient write or an ignored beat leaves the core ready for the next beat;
// a step runs eleven products (x*y shared by both coordinates) on one multiplier, each as
// four half-word partial products, a final accumulate, the fraction shift and the
// hand-back to the sequencer. One item is in work at a time; in ready is low while
// it runs. The result sits in an output register, so the next beat is taken while a result
// still waits on the out channel. frac_bits is written through cfg_we_i/cfg_wdata_i and
// must only change while the core is idle.
module quadratic_2d_map_fixed_point #(
  parameter int unsigned WORD_BITS = qmap_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  qmap_in_if.sink                     in_i,
  qmap_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [qmap_pkg::FRAC_W-1:0] cfg_wdata_i
);
  import qmap_pkg::*;

  // fraction-bit register
  logic [FRAC_W-1:0] frac_q, frac_d;

  // output register, the only buffer between the sequencer and the out channel
  logic               out_valid_q, out_valid_d;
  logic signed [63:0] out_x_q, out_x_d, out_y_q, out_y_d;

  ctrl_stat_t           stat;
  logic                 item;
  logic                 res_take;
  logic [WORD_BITS-1:0] cur_x, cur_y;

  // a beat is taken whenever the sequencer sits idle
  assign in_i.ready = stat.idle;
  assign item       = in_i.valid && stat.idle;

  // the output register can load when empty or being drained this cycle
  assign res_take = !out_valid_q || out_o.ready;

  qmap_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frac_bits_i  (frac_q),
    .item_i       (item),
    .opcode_i     (in_i.opcode),
    .coef_index_i (in_i.coef_index),
    .coef_value_i (in_i.coef_value[WORD_BITS-1:0]),
    .x_start_i    (in_i.x_start[WORD_BITS-1:0]),
    .y_start_i    (in_i.y_start[WORD_BITS-1:0]),
    .res_take_i   (res_take),
    .stat_o       (stat),
    .x_o          (cur_x),
    .y_o          (cur_y)
  );

  always_comb begin
    frac_d      = cfg_we_i ? cfg_wdata_i : frac_q;
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    if (stat.res_valid && res_take) begin
      // point comes out sign-extended from the working word
      out_valid_d = 1'b1;
      out_x_d     = 64'($signed(cur_x));
      out_y_d     = 64'($signed(cur_y));
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q      <= FRAC_RESET;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      frac_q      <= frac_d;
      out_valid_q <= out_valid_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.x_out = out_x_q;
  assign out_o.y_out = out_y_q;

endmodule

FILE: rtl/core/qmap_checker.sv
// qmap_checker: port-level assertions for the quadratic map core, bound to the top level
// uses qmap_pkg; depends on quadratic_2d_map_fixed_point
module qmap_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_opcode_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_x_i,
  input logic [63:0] out_y_i
);
  import qmap_pkg::*;

  logic in_beat, busy_op;

  assign in_beat = in_valid_i && in_ready_i;
  assign busy_op = (in_opcode_i == OP_LOAD) || (in_opcode_i == OP_STEP);

  // a waiting result beat is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_y_i))
    else $error("result payload changed while stalled");

  // load and step keep the core busy for at least the following cycle
  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && busy_op |=> !in_ready_i)
    else $error("core ready right after a load or step beat");

  // coefficient writes and ignored beats leave the core ready in the next cycle
  a_ready_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !busy_op |=> in_ready_i)
    else $error("core not ready after a coefficient write");

  // a new result only appears while the sequencer was busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without work in progress");

endmodule

bind quadratic_2d_map_fixed_point qmap_checker u_qmap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_opcode_i (in_i.opcode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.x_out),
  .out_y_i     (out_o.y_out)
);
